@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the grid interpolator RTL.
// Expects clk and rst_n (synchronous, active low) in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond holds at every edge out of reset
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// ante implies cons in the same cycle
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// ante implies cons in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/gbi_pkg.sv @@
// Shared constants, types and helpers for the grid bilinear interpolator.
// No dependencies.
package gbi_pkg;

  localparam int GRID_N     = 64;
  localparam int IDX_W      = ($clog2(GRID_N) < 2) ? 2 : $clog2(GRID_N);
  localparam int BANK_AW    = 2 * (IDX_W - 1);
  localparam int BANK_DEPTH = 1 << BANK_AW;
  localparam int DATA_W     = 32;
  localparam int COORD_W    = 32;
  localparam int REG_W      = 31;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = 62;
  localparam int WGT_W      = 33;
  localparam int ACC_W      = 64;
  localparam int ADDR_W     = 3;

  localparam logic [REG_W-1:0] LIMIT_RST = 31'd65536;
  localparam logic [REG_W-1:0] SCALE_RST = 31'd4194304;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic REG_LIMIT = 1'b0;
  localparam logic REG_SCALE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ABOVE = 2'd1,
    ST_NEG   = 2'd2
  } status_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } stage_load_t;

  typedef struct packed {
    logic              is_query;
    logic [1:0]        status;
    logic              we;
    logic [IDX_W-1:0]  wr0;
    logic [IDX_W-1:0]  wc0;
    logic [DATA_W-1:0] wdata;
    logic [IDX_W-1:0]  rlo;
    logic [IDX_W-1:0]  rhi;
    logic [IDX_W-1:0]  clo;
    logic [IDX_W-1:0]  chi;
    logic [FRAC_W-1:0] t;
    logic [FRAC_W-1:0] u;
  } loc_t;

  // grid index (1-based, unclamped) to clamped 0-based index
  function automatic logic [IDX_W-1:0] clamp_idx0(input logic [31:0] up);
    logic [31:0] m1;
    m1 = up - 32'd1;
    if (up == 32'd0) return '0;
    if (up > 32'(GRID_N)) return IDX_W'(GRID_N - 1);
    return m1[IDX_W-1:0];
  endfunction

endpackage

@@ hw/rtl/gbi_bank_ram.sv @@
// One bank of the grid store: one write port, one registered read port.
// Depends on gbi_pkg.
module gbi_bank_ram
  import gbi_pkg::*;
(
  input  logic               clk,
  input  logic               rd_en,
  input  logic [BANK_AW-1:0] raddr,
  output logic [DATA_W-1:0]  rdata,
  input  logic               we,
  input  logic [BANK_AW-1:0] waddr,
  input  logic [DATA_W-1:0]  wdata
);

  logic [DATA_W-1:0] mem [BANK_DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/gbi_locate.sv @@
// Stages 1-2: range check, coordinate scaling, neighbor indices and fractions.
// Depends on gbi_pkg.
module gbi_locate
  import gbi_pkg::*;
(
  input  logic                      clk,
  input  stage_load_t               ld,
  input  logic                      kind,
  input  logic [6:0]                write_row,
  input  logic [6:0]                write_col,
  input  logic signed [DATA_W-1:0]  write_value,
  input  logic signed [COORD_W-1:0] query_x,
  input  logic signed [COORD_W-1:0] query_y,
  input  logic [REG_W-1:0]          coord_limit,
  input  logic [REG_W-1:0]          cells_per_unit,
  output loc_t                      loc
);

  localparam logic [ACC_W-1:0] ROUND_OFS = 64'h0000_0001_8000_0000;

  logic              q1_r, q1_nxt;
  logic [1:0]        st1_r, st1_nxt;
  logic              we1_r, we1_nxt;
  logic [IDX_W-1:0]  wr1_r, wr1_nxt;
  logic [IDX_W-1:0]  wc1_r, wc1_nxt;
  logic [DATA_W-1:0] wd1_r, wd1_nxt;
  logic [PROD_W-1:0] px1_r, px1_nxt;
  logic [PROD_W-1:0] py1_r, py1_nxt;
  loc_t              loc_r, loc_nxt;

  logic              above, neg;
  logic [ACC_W-1:0]  rx, ry;
  logic [31:0]       upx, upy;

  always_comb begin
    above = (!query_x[COORD_W-1] && (query_x[COORD_W-2:0] > coord_limit)) ||
            (!query_y[COORD_W-1] && (query_y[COORD_W-2:0] > coord_limit));
    neg   = query_x[COORD_W-1] || query_y[COORD_W-1];
    q1_nxt = (kind == KIND_QUERY);
    if (above) begin
      st1_nxt = ST_ABOVE;
    end else if (neg) begin
      st1_nxt = ST_NEG;
    end else begin
      st1_nxt = ST_OK;
    end
    we1_nxt = (kind == KIND_WRITE) &&
              (write_row != 7'd0) && ({25'd0, write_row} <= 32'(GRID_N)) &&
              (write_col != 7'd0) && ({25'd0, write_col} <= 32'(GRID_N));
    wr1_nxt = IDX_W'(write_row - 7'd1);
    wc1_nxt = IDX_W'(write_col - 7'd1);
    wd1_nxt = write_value;
    px1_nxt = query_x[COORD_W-2:0] * cells_per_unit;
    py1_nxt = query_y[COORD_W-2:0] * cells_per_unit;
  end

  always_ff @(posedge clk) begin
    if (ld.s1) begin
      q1_r  <= q1_nxt;
      st1_r <= st1_nxt;
      we1_r <= we1_nxt;
      wr1_r <= wr1_nxt;
      wc1_r <= wc1_nxt;
      wd1_r <= wd1_nxt;
      px1_r <= px1_nxt;
      py1_r <= py1_nxt;
    end
  end

  always_comb begin
    rx  = {2'b00, px1_r} + ROUND_OFS;
    ry  = {2'b00, py1_r} + ROUND_OFS;
    upx = rx[ACC_W-1:32];
    upy = ry[ACC_W-1:32];
    loc_nxt.is_query = q1_r;
    loc_nxt.status   = st1_r;
    loc_nxt.we       = we1_r;
    loc_nxt.wr0      = wr1_r;
    loc_nxt.wc0      = wc1_r;
    loc_nxt.wdata    = wd1_r;
    loc_nxt.rlo      = clamp_idx0(upx - 32'd1);
    loc_nxt.rhi      = clamp_idx0(upx);
    loc_nxt.clo      = clamp_idx0(upy - 32'd1);
    loc_nxt.chi      = clamp_idx0(upy);
    loc_nxt.t        = rx[31:16];
    loc_nxt.u        = ry[31:16];
  end

  always_ff @(posedge clk) begin
    if (ld.s2) begin
      loc_r <= loc_nxt;
    end
  end

  assign loc = loc_r;

endmodule

@@ hw/rtl/gbi_grid.sv @@
// Stage 3 grid store: four banks split by row and column parity, so the
// four neighbors of a query come out in the same cycle. Depends on gbi_pkg, gbi_bank_ram.
module gbi_grid
  import gbi_pkg::*;
(
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic                     wr_go,
  input  loc_t                     loc,
  output logic signed [DATA_W-1:0] e_ll,
  output logic signed [DATA_W-1:0] e_hl,
  output logic signed [DATA_W-1:0] e_lh,
  output logic signed [DATA_W-1:0] e_hh
);

  logic [DATA_W-1:0] bank_q [4];
  logic              rlo_p_r, rhi_p_r, clo_p_r, chi_p_r;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic PR = 1'((b >> 1) & 1);
    localparam logic PC = 1'(b & 1);
    logic [IDX_W-1:0]   row_sel, col_sel;
    logic [BANK_AW-1:0] raddr, waddr;
    logic               bwe;

    assign row_sel = (loc.rlo[0] == PR) ? loc.rlo : loc.rhi;
    assign col_sel = (loc.clo[0] == PC) ? loc.clo : loc.chi;
    assign raddr   = {row_sel[IDX_W-1:1], col_sel[IDX_W-1:1]};
    assign waddr   = {loc.wr0[IDX_W-1:1], loc.wc0[IDX_W-1:1]};
    assign bwe     = wr_go && loc.we && (loc.wr0[0] == PR) && (loc.wc0[0] == PC);

    gbi_bank_ram u_ram (
      .clk   (clk),
      .rd_en (rd_en),
      .raddr (raddr),
      .rdata (bank_q[b]),
      .we    (bwe),
      .waddr (waddr),
      .wdata (loc.wdata)
    );
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rlo_p_r <= loc.rlo[0];
      rhi_p_r <= loc.rhi[0];
      clo_p_r <= loc.clo[0];
      chi_p_r <= loc.chi[0];
    end
  end

  assign e_ll = bank_q[{rlo_p_r, clo_p_r}];
  assign e_hl = bank_q[{rhi_p_r, clo_p_r}];
  assign e_lh = bank_q[{rlo_p_r, chi_p_r}];
  assign e_hh = bank_q[{rhi_p_r, chi_p_r}];

endmodule

@@ hw/rtl/gbi_blend.sv @@
// Stages 3-6: bilinear weights, weighted products, sum, rounding, saturation.
// Depends on gbi_pkg.
module gbi_blend
  import gbi_pkg::*;
(
  input  logic                     clk,
  input  stage_load_t              ld,
  input  loc_t                     loc,
  input  logic signed [DATA_W-1:0] e_ll,
  input  logic signed [DATA_W-1:0] e_hl,
  input  logic signed [DATA_W-1:0] e_lh,
  input  logic signed [DATA_W-1:0] e_hh,
  output logic signed [DATA_W-1:0] interp_value,
  output logic [1:0]               status
);

  localparam logic [FRAC_W:0]  ONE_Q16  = 17'h1_0000;
  localparam logic signed [ACC_W:0] HALF_Q32 = 65'sh0_8000_0000;

  logic [FRAC_W:0]        t1, u1;
  logic [2*FRAC_W+1:0]    m_ll, m_hl, m_lh, m_hh;
  logic [WGT_W-1:0]       w_ll_r, w_hl_r, w_lh_r, w_hh_r;
  logic [1:0]             st3_r, st4_r, st5_r;
  logic signed [65:0]     prod_ll, prod_hl, prod_lh, prod_hh;
  logic [ACC_W-1:0]       p_ll_r, p_hl_r, p_lh_r, p_hh_r;
  logic [ACC_W-1:0]       sa_r, sb_r;
  logic [ACC_W-1:0]       total;
  logic signed [ACC_W:0]  rnd;
  logic [32:0]            val;
  logic [DATA_W-1:0]      sat;
  logic [DATA_W-1:0]      value_r, value_nxt;
  logic [1:0]             status_r;

  // stage 3: weights, alongside the bank read
  always_comb begin
    t1   = ONE_Q16 - {1'b0, loc.t};
    u1   = ONE_Q16 - {1'b0, loc.u};
    m_ll = t1 * u1;
    m_hl = {1'b0, loc.t} * u1;
    m_lh = t1 * {1'b0, loc.u};
    m_hh = {1'b0, loc.t} * {1'b0, loc.u};
  end

  always_ff @(posedge clk) begin
    if (ld.s3) begin
      w_ll_r <= m_ll[WGT_W-1:0];
      w_hl_r <= m_hl[WGT_W-1:0];
      w_lh_r <= m_lh[WGT_W-1:0];
      w_hh_r <= m_hh[WGT_W-1:0];
      st3_r  <= loc.status;
    end
  end

  // stage 4: weighted products
  assign prod_ll = e_ll * $signed({1'b0, w_ll_r});
  assign prod_hl = e_hl * $signed({1'b0, w_hl_r});
  assign prod_lh = e_lh * $signed({1'b0, w_lh_r});
  assign prod_hh = e_hh * $signed({1'b0, w_hh_r});

  always_ff @(posedge clk) begin
    if (ld.s4) begin
      p_ll_r <= prod_ll[ACC_W-1:0];
      p_hl_r <= prod_hl[ACC_W-1:0];
      p_lh_r <= prod_lh[ACC_W-1:0];
      p_hh_r <= prod_hh[ACC_W-1:0];
      st4_r  <= st3_r;
    end
  end

  // stage 5: pair sums
  always_ff @(posedge clk) begin
    if (ld.s5) begin
      sa_r  <= p_ll_r + p_hl_r;
      sb_r  <= p_lh_r + p_hh_r;
      st5_r <= st4_r;
    end
  end

  // stage 6: final sum, round half up, saturate
  always_comb begin
    total = sa_r + sb_r;
    rnd   = $signed({total[ACC_W-1], total}) + HALF_Q32;
    val   = rnd[ACC_W:32];
    if (val[32] != val[31]) begin
      sat = val[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      sat = val[31:0];
    end
    value_nxt = (st5_r == ST_OK) ? sat : '0;
  end

  always_ff @(posedge clk) begin
    if (ld.s6) begin
      value_r  <= value_nxt;
      status_r <= st5_r;
    end
  end

  assign interp_value = value_r;
  assign status       = status_r;

endmodule

@@ hw/rtl/grid_bilinear_interpolator.sv @@
// Top level: handshake control, configuration registers, pipeline assembly.
// Depends on gbi_pkg, gbi_locate, gbi_grid, gbi_blend, assert_macros.svh.
//
//   channel | direction | handshake         | payload
//   in      | input     | in_valid/in_stall | kind, write_row/col/value, query_x/y
//   out     | output    | out_valid/out_stall | interp_value, status
//   cfg     | input     | psel/penable/pready | paddr, pwdata, prdata
//
// One item per cycle while out_stall is low; a query's result passes through
// six register stages: scale multiply, locate, bank read with weights, weighted
// products and two adder stages.
// Grid writes land at stage 3, ahead of any later query's bank read.
// Reset clears stage valid bits and sets the config registers to defaults; grid contents are undefined.
// A stalled output holds; upstream stages keep filling until each holds an item.
`include "assert_macros.svh"

module grid_bilinear_interpolator
  import gbi_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_kind,
  input  logic [6:0]                in_write_row,
  input  logic [6:0]                in_write_col,
  input  logic signed [DATA_W-1:0]  in_write_value,
  input  logic signed [COORD_W-1:0] in_query_x,
  input  logic signed [COORD_W-1:0] in_query_y,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [DATA_W-1:0]  out_interp_value,
  output logic [1:0]                out_status,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  logic [REG_W-1:0] limit_r, limit_nxt;
  logic [REG_W-1:0] scale_r, scale_nxt;
  logic             v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic             v1_nxt, v2_nxt, v3_nxt, v4_nxt, v5_nxt, v6_nxt;
  logic             cfg_we;
  logic             pipe_empty;
  logic             err_out;
  stage_load_t      ld;
  loc_t             loc;
  logic signed [DATA_W-1:0] e_ll, e_hl, e_lh, e_hh;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    limit_nxt = limit_r;
    scale_nxt = scale_r;
    if (cfg_we) begin
      case (paddr[2])
        REG_LIMIT: limit_nxt = pwdata[REG_W-1:0];
        REG_SCALE: scale_nxt = pwdata[REG_W-1:0];
        default:   limit_nxt = limit_r;
      endcase
    end
    case (paddr[2])
      REG_LIMIT: prdata = {1'b0, limit_r};
      REG_SCALE: prdata = {1'b0, scale_r};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RST;
      scale_r <= SCALE_RST;
    end else begin
      limit_r <= limit_nxt;
      scale_r <= scale_nxt;
    end
  end

  // a stage loads when it is empty or its item moves on
  always_comb begin
    ld.s6 = !v6_r || !out_stall;
    ld.s5 = !v5_r || ld.s6;
    ld.s4 = !v4_r || ld.s5;
    ld.s3 = !v3_r || ld.s4;
    ld.s2 = !v2_r || ld.s3;
    ld.s1 = !v1_r || ld.s2;
    v1_nxt = ld.s1 ? in_valid : v1_r;
    v2_nxt = ld.s2 ? v1_r : v2_r;
    v3_nxt = ld.s3 ? (v2_r && loc.is_query) : v3_r;
    v4_nxt = ld.s4 ? v3_r : v4_r;
    v5_nxt = ld.s5 ? v4_r : v5_r;
    v6_nxt = ld.s6 ? v5_r : v6_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
      v5_r <= v5_nxt;
      v6_r <= v6_nxt;
    end
  end

  assign in_stall  = !ld.s1;
  assign out_valid = v6_r;

  gbi_locate u_locate (
    .clk            (clk),
    .ld             (ld),
    .kind           (in_kind),
    .write_row      (in_write_row),
    .write_col      (in_write_col),
    .write_value    (in_write_value),
    .query_x        (in_query_x),
    .query_y        (in_query_y),
    .coord_limit    (limit_r),
    .cells_per_unit (scale_r),
    .loc            (loc)
  );

  gbi_grid u_grid (
    .clk   (clk),
    .rd_en (ld.s3),
    .wr_go (ld.s3 && v2_r),
    .loc   (loc),
    .e_ll  (e_ll),
    .e_hl  (e_hl),
    .e_lh  (e_lh),
    .e_hh  (e_hh)
  );

  gbi_blend u_blend (
    .clk          (clk),
    .ld           (ld),
    .loc          (loc),
    .e_ll         (e_ll),
    .e_hl         (e_hl),
    .e_lh         (e_lh),
    .e_hh         (e_hh),
    .interp_value (out_interp_value),
    .status       (out_status)
  );

  assign pipe_empty = !(v1_r || v2_r || v3_r || v4_r || v5_r || v6_r);
  assign err_out    = out_valid && (out_status != ST_OK);

  `ASSERT_IMPL(a_drain_accepts, !out_stall, !in_stall, "input stalled while output drains")
  `ASSERT_NEXT(a_empty_no_result, pipe_empty, !out_valid, "result from an empty pipeline")
  `ASSERT_IMPL(a_error_zero, err_out, out_interp_value == '0, "error item with nonzero value")

endmodule

@@ sim/tb_grid_bilinear_interpolator.sv @@
// Testbench for grid_bilinear_interpolator: grid writes and interpolation queries
// under random idle and stall bursts, each result predicted at accept and checked.
// Depends on gbi_pkg and the block's RTL only.
module tb_grid_bilinear_interpolator;
  import gbi_pkg::*;

  localparam int NUM_PHASES   = 7;
  localparam int DRAIN_CYCLES = 12;

  typedef struct {
    logic               kind;
    logic [6:0]         row;
    logic [6:0]         col;
    logic signed [31:0] value;
    logic signed [31:0] qx;
    logic signed [31:0] qy;
  } grid_item_t;

  typedef struct {
    logic signed [31:0] value;
    status_t            status;
  } interp_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_kind = KIND_WRITE;
  logic [6:0]                in_write_row = '0;
  logic [6:0]                in_write_col = '0;
  logic signed [DATA_W-1:0]  in_write_value = '0;
  logic signed [COORD_W-1:0] in_query_x = '0;
  logic signed [COORD_W-1:0] in_query_y = '0;
  logic                      out_stall = 1'b0;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [ADDR_W-1:0]         paddr = '0;
  logic [31:0]               pwdata = '0;
  logic                      in_stall;
  logic                      out_valid;
  logic signed [DATA_W-1:0]  out_interp_value;
  logic [1:0]                out_status;
  logic [31:0]               prdata;
  logic                      pready;

  grid_item_t     pending_items[$];
  interp_result_t awaited_interp[$];
  grid_item_t     cur_item;
  interp_result_t pred_res;
  interp_result_t head_res;
  int             grid_model [GRID_N][GRID_N];
  bit             gen_written [GRID_N][GRID_N];
  logic [REG_W-1:0] cfg_limit = LIMIT_RST;
  logic [REG_W-1:0] cfg_scale = SCALE_RST;
  int mismatch_count = 0;
  bit item_taken = 1'b0;
  bit idle_enabled = 1'b1;
  int in_gap_left = 0;
  int out_hold_left = 0;
  int calm_left = 0;

  int unsigned phase_limit [NUM_PHASES] =
    '{32'd65536, 32'd0, 32'h7FFF_FFFF, 32'd1, 32'd1000000, 32'd4194304, 32'd65536};
  int unsigned phase_scale [NUM_PHASES] =
    '{32'd4194304, 32'd0, 32'd128, 32'h7FFF_FFFF, 32'd274877, 32'd65536, 32'd4194304};
  int phase_items [NUM_PHASES] = '{90, 60, 110, 70, 110, 110, 150};

  grid_bilinear_interpolator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_write_row(in_write_row), .in_write_col(in_write_col),
    .in_write_value(in_write_value), .in_query_x(in_query_x), .in_query_y(in_query_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_interp_value(out_interp_value), .out_status(out_status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic int unsigned clamp_to_grid(input logic [31:0] up);
    if (up < 1) return 1;
    if (up > GRID_N) return GRID_N;
    return up;
  endfunction

  // scaled coordinate in Q32.32, rounded half up to the upper neighbor
  function automatic void grid_position(input logic [31:0] c, output int unsigned lo,
                                        output int unsigned hi, output logic [15:0] frac);
    logic [63:0] r;
    r = 64'(c) * 64'(cfg_scale) + 64'h1_8000_0000;
    frac = r[31:16];
    hi = clamp_to_grid(r[63:32]);
    lo = clamp_to_grid(r[63:32] - 32'd1);
  endfunction

  function automatic bit interpolate_item(input grid_item_t it, output interp_result_t res);
    logic signed [31:0] lim;
    int unsigned rlo, rhi, clo, chi;
    logic [15:0] t, u;
    longint t1, u1, ts, us, acc;
    logic [63:0] biased;
    res.value = '0;
    res.status = ST_OK;
    if (it.kind == KIND_WRITE) begin
      if (it.row >= 1 && it.row <= GRID_N && it.col >= 1 && it.col <= GRID_N)
        grid_model[it.row-1][it.col-1] = it.value;
      return 1'b0;
    end
    lim = {1'b0, cfg_limit};
    if (it.qx > lim || it.qy > lim) begin
      res.status = ST_ABOVE;
      return 1'b1;
    end
    if (it.qx < 0 || it.qy < 0) begin
      res.status = ST_NEG;
      return 1'b1;
    end
    grid_position(it.qx, rlo, rhi, t);
    grid_position(it.qy, clo, chi, u);
    t1 = 65536 - longint'(t);
    u1 = 65536 - longint'(u);
    ts = longint'(t);
    us = longint'(u);
    acc = longint'(grid_model[rlo-1][clo-1]) * (t1 * u1)
        + longint'(grid_model[rhi-1][clo-1]) * (ts * u1)
        + longint'(grid_model[rlo-1][chi-1]) * (t1 * us)
        + longint'(grid_model[rhi-1][chi-1]) * (ts * us);
    // round half toward plus infinity on the offset-binary form
    biased = (64'(acc) ^ 64'h8000_0000_0000_0000) + 64'h8000_0000;
    res.value = biased[63:32] ^ 32'h8000_0000;
    return 1'b1;
  endfunction

  function automatic logic [31:0] sample_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_write(input logic [6:0] row, input logic [6:0] col,
                            input logic [31:0] value);
    grid_item_t it;
    it.kind = KIND_WRITE;
    it.row = row;
    it.col = col;
    it.value = value;
    it.qx = $urandom;
    it.qy = $urandom;
    pending_items.push_back(it);
    if (row >= 1 && row <= GRID_N && col >= 1 && col <= GRID_N)
      gen_written[row-1][col-1] = 1'b1;
  endtask

  task automatic fill_entry(input int unsigned row, input int unsigned col);
    if (!gen_written[row-1][col-1])
      push_write(7'(row), 7'(col), sample_value());
  endtask

  // a query that reads the grid is preceded by writes to any neighbor not yet loaded
  task automatic push_query(input logic [31:0] x, input logic [31:0] y);
    grid_item_t it;
    int unsigned rlo, rhi, clo, chi;
    logic [15:0] t, u;
    if (!x[31] && !y[31] && x <= {1'b0, cfg_limit} && y <= {1'b0, cfg_limit}) begin
      grid_position(x, rlo, rhi, t);
      grid_position(y, clo, chi, u);
      fill_entry(rlo, clo);
      fill_entry(rhi, clo);
      fill_entry(rlo, chi);
      fill_entry(rhi, chi);
    end
    it.kind = KIND_QUERY;
    it.row = 7'($urandom);
    it.col = 7'($urandom);
    it.value = $urandom;
    it.qx = x;
    it.qy = y;
    pending_items.push_back(it);
  endtask

  task automatic push_random_item();
    logic [31:0] lim, a, b, c;
    logic [6:0] bad, other;
    int pick;
    lim = {1'b0, cfg_limit};
    a = $urandom_range(0, lim);
    b = $urandom_range(0, lim);
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      push_write(7'($urandom_range(1, GRID_N)), 7'($urandom_range(1, GRID_N)), sample_value());
    end else if (pick < 25) begin
      bad = $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(GRID_N + 1, 127));
      other = 7'($urandom_range(0, 127));
      if ($urandom_range(0, 1)) push_write(bad, other, $urandom);
      else push_write(other, bad, $urandom);
    end else if (pick < 85) begin
      push_query(a, b);
    end else if (pick < 90) begin
      c = $urandom_range(0, 1) ? lim : 32'd0;
      if ($urandom_range(0, 1)) push_query(c, b);
      else push_query(a, c);
    end else begin
      if (pick < 95)
        c = (lim == 32'h7FFF_FFFF) ? lim : $urandom_range(lim + 1, 32'h7FFF_FFFF);
      else
        c = $urandom_range(32'h8000_0000, 32'hFFFF_FFFF);
      b = $urandom_range(0, 1) ? b : $urandom;
      if ($urandom_range(0, 1)) push_query(c, b);
      else push_query(b, c);
    end
  endtask

  task automatic write_register(input logic idx, input logic [REG_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {1'($urandom_range(0, 1)), value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_LIMIT) cfg_limit = value;
    else cfg_scale = value;
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[REG_W-1:0] !== value)
      flag_mismatch($sformatf("register %0d reads %h, want %h", idx, prdata, value));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || awaited_interp.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // driver: input items and output stall, changed at the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(0, 99) == 0) calm_left = $urandom_range(16, 64);
      if (!in_valid || item_taken) begin
        item_taken = 1'b0;
        if (in_gap_left == 0 && idle_enabled && calm_left == 0 && $urandom_range(0, 7) == 0)
          in_gap_left = $urandom_range(1, 4);
        if (in_gap_left > 0 || pending_items.size() == 0) begin
          if (in_gap_left > 0) in_gap_left--;
          in_valid <= 1'b0;
        end else begin
          cur_item = pending_items.pop_front();
          in_valid <= 1'b1;
          in_kind <= cur_item.kind;
          in_write_row <= cur_item.row;
          in_write_col <= cur_item.col;
          in_write_value <= cur_item.value;
          in_query_x <= cur_item.qx;
          in_query_y <= cur_item.qy;
        end
      end
      if (out_hold_left == 0 && idle_enabled && calm_left == 0 && $urandom_range(0, 5) == 0)
        out_hold_left = $urandom_range(1, 4);
      if (out_hold_left > 0) begin
        out_hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // monitor: accepted items feed the model, accepted results are checked
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      item_taken = 1'b1;
      if (interpolate_item(cur_item, pred_res)) awaited_interp.push_back(pred_res);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_interp.size() == 0) begin
        flag_mismatch($sformatf("result %h status %0d with none awaited",
                                out_interp_value, out_status));
      end else begin
        head_res = awaited_interp.pop_front();
        if (out_interp_value !== head_res.value)
          flag_mismatch($sformatf("interp_value %h, want %h", out_interp_value, head_res.value));
        if (out_status !== head_res.status)
          flag_mismatch($sformatf("status %0d, want %0d", out_status, head_res.status));
      end
    end
  end

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        wait_idle();
        write_register(REG_LIMIT, REG_W'(phase_limit[p]));
        write_register(REG_SCALE, REG_W'(phase_scale[p]));
      end
      idle_enabled = (p != NUM_PHASES - 1);
      if (p == 0) begin
        // corners with extreme values, ignored writes, then edge and error queries
        push_write(7'd1, 7'd1, 32'h7FFF_FFFF);
        push_write(7'd64, 7'd64, 32'h8000_0000);
        push_write(7'd1, 7'd64, 32'd0);
        push_write(7'd64, 7'd1, 32'd1);
        push_write(7'd0, 7'd5, $urandom);
        push_write(7'd5, 7'd0, $urandom);
        push_write(7'd65, 7'd3, $urandom);
        push_write(7'd127, 7'd127, $urandom);
        push_write(7'd3, 7'd127, $urandom);
        push_query(32'd0, 32'd0);
        push_query(32'd65536, 32'd65536);
        push_query(32'd0, 32'd65536);
        push_query(32'd65536, 32'd0);
        push_query(32'd32768, 32'd32768);
        push_query(32'd512, 32'd1024);
        push_query(32'd1023, 32'd33000);
        push_query(32'd65537, 32'd0);
        push_query(32'd0, 32'hFFFF_FFFF);
        push_query(32'hFFFF_FFFF, 32'd65537);
        push_query(32'h8000_0000, 32'h7FFF_FFFF);
        push_query(32'h8000_0000, 32'd0);
      end
      repeat (phase_items[p]) push_random_item();
    end
    wait_idle();
    if (mismatch_count == 0)
      $display("grid_bilinear_interpolator verification clean");
    else
      $display("grid_bilinear_interpolator verification failed");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("grid_bilinear_interpolator verification failed");
    $finish;
  end

endmodule
